// ===== design/sponge_hash_2048_permutation_defines.svh =====
// assertion macros used by the sponge hash design file sh2048_back
// needs clk and rst_n in the scope of each use
`ifndef SPONGE_HASH_2048_PERMUTATION_DEFINES_SVH
`define SPONGE_HASH_2048_PERMUTATION_DEFINES_SVH

// same-cycle implication
`define SH_CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sponge hash check failed");

// next-cycle implication
`define SH_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sponge hash check failed");

`endif

// ===== design/sh2048_pkg.sv =====
// shared types, constants and round function of the sponge hash
// no dependencies
package sh2048_pkg;

    localparam int RATE_WORDS_DEF   = 20;
    localparam int DIGEST_WORDS_DEF = 6;
    localparam int STATE_WORDS      = 32;
    localparam int MAX_ROUNDS       = 24;

    typedef logic [STATE_WORDS-1:0][63:0] state_t;

    typedef struct packed {
        logic [63:0] word;
        logic [63:0] pad_word;
        logic        last;
        logic        full_last;
    } item_t;

    function automatic logic [7:0] round_const(input logic [4:0] r);
        logic [7:0] c;
        case (r)
            5'd0:  c = 8'h24;
            5'd1:  c = 8'h3f;
            5'd2:  c = 8'h6a;
            5'd3:  c = 8'h88;
            5'd4:  c = 8'h85;
            5'd5:  c = 8'ha3;
            5'd6:  c = 8'h08;
            5'd7:  c = 8'hd3;
            5'd8:  c = 8'h13;
            5'd9:  c = 8'h19;
            5'd10: c = 8'h8a;
            5'd11: c = 8'h2e;
            5'd12: c = 8'h03;
            5'd13: c = 8'h70;
            5'd14: c = 8'h73;
            5'd15: c = 8'h44;
            5'd16: c = 8'ha4;
            5'd17: c = 8'h09;
            5'd18: c = 8'h38;
            5'd19: c = 8'h22;
            5'd20: c = 8'h29;
            5'd21: c = 8'h9f;
            5'd22: c = 8'h31;
            5'd23: c = 8'hd0;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] rot_amount(input logic [1:0] rs, input logic [1:0] row);
        logic [6:0] n;
        case ({rs, row})
            4'b00_01: n = 7'd14;
            4'b00_10: n = 7'd20;
            4'b00_11: n = 7'd22;
            4'b01_01: n = 7'd13;
            4'b01_10: n = 7'd68;
            4'b01_11: n = 7'd91;
            4'b10_01: n = 7'd27;
            4'b10_10: n = 7'd42;
            4'b10_11: n = 7'd106;
            4'b11_01: n = 7'd32;
            4'b11_10: n = 7'd48;
            4'b11_11: n = 7'd80;
            default:  n = 7'd0;
        endcase
        return n;
    endfunction

    function automatic state_t perm_round(input state_t s, input logic [4:0] r);
        logic [3:0][3:0][127:0] m;
        logic [127:0] a0, a1, a2, a3, b0, b1, b2, b3, t;
        logic [255:0] dbl;
        state_t o;
        for (int row = 0; row < 4; row++)
        begin
            for (int col = 0; col < 4; col++)
            begin
                m[row][col] = {s[2*(col*4+row)+1], s[2*(col*4+row)]};
            end
        end
        // s-box
        for (int row = 0; row < 4; row++)
        begin
            a0 = m[row][0];
            a1 = m[row][1];
            a2 = m[row][2];
            a3 = m[row][3];
            b3 = (a3 & a2) ^ a1;
            b1 = (a2 | a1) ^ a0;
            b0 = (b3 & a0) ^ a3;
            b2 = (b1 & a3) ^ a2;
            m[row][0] = b0;
            m[row][1] = b1;
            m[row][2] = b2;
            m[row][3] = b3;
        end
        // column mixing
        m[2] = m[2] ^ m[3];
        m[0] = m[0] ^ m[1];
        t = m[1][3]; m[1][3] = m[1][2]; m[1][2] = m[1][1]; m[1][1] = t ^ m[1][0]; m[1][0] = t;
        t = m[3][3]; m[3][3] = m[3][2]; m[3][2] = m[3][1]; m[3][1] = t ^ m[3][0]; m[3][0] = t;
        m[1] = m[1] ^ m[2];
        m[3] = m[3] ^ m[0];
        for (int k = 0; k < 2; k++)
        begin
            t = m[0][3]; m[0][3] = m[0][2]; m[0][2] = m[0][1]; m[0][1] = t ^ m[0][0]; m[0][0] = t;
            t = m[2][3]; m[2][3] = m[2][2]; m[2][2] = m[2][1]; m[2][1] = t ^ m[2][0]; m[2][0] = t;
        end
        m[2] = m[2] ^ m[3];
        m[0] = m[0] ^ m[1];
        m[1] = m[1] ^ m[2];
        m[3] = m[3] ^ m[0];
        // row rotations
        for (int row = 1; row < 4; row++)
        begin
            for (int col = 0; col < 4; col++)
            begin
                dbl = {m[row][col], m[row][col]} >> rot_amount(r[1:0], 2'(row));
                m[row][col] = dbl[127:0];
            end
        end
        m[3][3][7:0] = m[3][3][7:0] ^ round_const(r);
        for (int row = 0; row < 4; row++)
        begin
            for (int col = 0; col < 4; col++)
            begin
                o[2*(col*4+row)]   = m[row][col][63:0];
                o[2*(col*4+row)+1] = m[row][col][127:64];
            end
        end
        return o;
    endfunction

endpackage

// ===== design/sh2048_front.sv =====
// input queue and padding classification of message words
// depends on sh2048_pkg
module sh2048_front
    import sh2048_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] message_word,
    input  logic [6:0]  valid_bits,
    input  logic        last_word,
    output logic        item_valid,
    output item_t       item,
    input  logic        item_pop
);

    item_t       q_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  cnt_reg;
    item_t       cls;
    logic        do_push;

    // padded word: bit index within message is msb-first per byte
    always_comb
    begin
        cls.word      = message_word;
        cls.last      = last_word;
        cls.full_last = last_word && (valid_bits >= 7'd64);
        for (int i = 0; i < 64; i++)
        begin
            if (7'(8*(i/8) + 7 - (i%8)) < valid_bits)
                cls.pad_word[i] = message_word[i];
            else
                cls.pad_word[i] = (7'(8*(i/8) + 7 - (i%8)) == valid_bits);
        end
    end

    assign full       = (cnt_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (item_pop)
                rptr_reg <= !rptr_reg;
            case ({do_push, item_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== design/sh2048_back.sv =====
// sponge state, absorb, permutation rounds and digest queue
// depends on sh2048_pkg and the assertion macro header
`include "sponge_hash_2048_permutation_defines.svh"
module sh2048_back
    import sh2048_pkg::*;
#(
    parameter int RATE_WORDS   = RATE_WORDS_DEF,
    parameter int DIGEST_WORDS = DIGEST_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_pop,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  round_count,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] digest_word,
    output logic        digest_last
);

    localparam int POS_W = $clog2(RATE_WORDS + 1);
    localparam int DIG_W = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_PERM, ST_DIGEST} st_t;

    st_t              st_reg;
    state_t           state_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_inc;
    logic [4:0]       rnd_reg;
    logic [4:0]       rounds_reg;
    logic [4:0]       nr;
    logic             pad_reg;
    logic             final_reg;
    logic [DIG_W-1:0] didx_reg;
    logic [63:0]      oq_word_reg [2];
    logic             oq_last_reg [2];
    logic             oq_wptr_reg;
    logic             oq_rptr_reg;
    logic [1:0]       oq_cnt_reg;
    logic             oq_push;
    logic             oq_pop;
    logic             dig_end;

    assign cfg_ready   = 1'b1;
    assign nr          = (rounds_reg > 5'(MAX_ROUNDS)) ? 5'(MAX_ROUNDS) : rounds_reg;
    assign pos_inc     = pos_reg + 1'b1;
    assign item_pop    = (st_reg == ST_IDLE) && item_valid;
    assign empty       = (oq_cnt_reg == 2'd0);
    assign oq_pop      = pop && !empty;
    assign oq_push     = (st_reg == ST_DIGEST) && (oq_cnt_reg != 2'd2);
    assign dig_end     = (didx_reg == DIG_W'(DIGEST_WORDS - 1));
    assign digest_word = oq_word_reg[oq_rptr_reg];
    assign digest_last = oq_last_reg[oq_rptr_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_word_reg[oq_wptr_reg] <= state_reg[5'(didx_reg)];
            oq_last_reg[oq_wptr_reg] <= dig_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            state_reg   <= '0;
            pos_reg     <= '0;
            rnd_reg     <= '0;
            rounds_reg  <= 5'd20;
            pad_reg     <= 1'b0;
            final_reg   <= 1'b0;
            didx_reg    <= '0;
            oq_wptr_reg <= 1'b0;
            oq_rptr_reg <= 1'b0;
            oq_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_valid)
                rounds_reg <= round_count;
            if (oq_push)
                oq_wptr_reg <= !oq_wptr_reg;
            if (oq_pop)
                oq_rptr_reg <= !oq_rptr_reg;
            case ({oq_push, oq_pop})
                2'b10:   oq_cnt_reg <= oq_cnt_reg + 2'd1;
                2'b01:   oq_cnt_reg <= oq_cnt_reg - 2'd1;
                default: oq_cnt_reg <= oq_cnt_reg;
            endcase

            unique case (st_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (!item.last)
                        begin
                            state_reg[5'(pos_reg)] <= state_reg[5'(pos_reg)] ^ item.word;
                            final_reg <= 1'b0;
                            pad_reg   <= 1'b0;
                            if (pos_inc == POS_W'(RATE_WORDS))
                            begin
                                pos_reg <= '0;
                                st_reg  <= ST_PERM;
                            end
                            else
                            begin
                                pos_reg <= pos_inc;
                            end
                        end
                        else if (!item.full_last)
                        begin
                            state_reg[5'(pos_reg)] <= state_reg[5'(pos_reg)] ^ item.pad_word;
                            pos_reg   <= '0;
                            final_reg <= 1'b1;
                            pad_reg   <= 1'b0;
                            st_reg    <= ST_PERM;
                        end
                        else
                        begin
                            // full final word, pad bit opens the next word
                            state_reg[5'(pos_reg)] <= state_reg[5'(pos_reg)] ^ item.word;
                            if (pos_inc == POS_W'(RATE_WORDS))
                            begin
                                pad_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg[5'(pos_inc)] <= state_reg[5'(pos_inc)] ^ 64'h80;
                                pad_reg <= 1'b0;
                            end
                            pos_reg   <= '0;
                            final_reg <= 1'b1;
                            st_reg    <= ST_PERM;
                        end
                    end
                end
                ST_PERM:
                begin
                    if (rnd_reg < nr)
                    begin
                        state_reg <= perm_round(state_reg, rnd_reg);
                        rnd_reg   <= rnd_reg + 5'd1;
                    end
                    else
                    begin
                        rnd_reg <= '0;
                        if (pad_reg)
                        begin
                            state_reg[0] <= state_reg[0] ^ 64'h80;
                            pad_reg      <= 1'b0;
                        end
                        else if (final_reg)
                        begin
                            didx_reg <= '0;
                            st_reg   <= ST_DIGEST;
                        end
                        else
                        begin
                            st_reg <= ST_IDLE;
                        end
                    end
                end
                ST_DIGEST:
                begin
                    if (oq_push)
                    begin
                        if (dig_end)
                        begin
                            state_reg <= '0;
                            didx_reg  <= '0;
                            final_reg <= 1'b0;
                            st_reg    <= ST_IDLE;
                        end
                        else
                        begin
                            didx_reg <= didx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `SH_CHK_IMPL(a_rnd_bound, st_reg == ST_PERM, rnd_reg <= 5'(MAX_ROUNDS))
    `SH_CHK_NEXT(a_dig_clear, oq_push && dig_end, st_reg == ST_IDLE && state_reg == '0)
    `SH_CHK_NEXT(a_dig_hold, st_reg == ST_DIGEST && oq_cnt_reg == 2'd2 && !oq_pop,
                 $stable(didx_reg) && oq_cnt_reg == 2'd2)
    `SH_CHK_NEXT(a_block_perm, item_pop && !item.last && pos_inc == POS_W'(RATE_WORDS),
                 st_reg == ST_PERM && pos_reg == '0)

endmodule

// ===== design/sponge_hash_2048_permutation.sv =====
// sponge hash over a 2048-bit state with a configurable round permutation
// top level; depends on sh2048_pkg, sh2048_front and sh2048_back
//
// input side is a queue: message_word/valid_bits/last_word are taken when
// push is high and full is low; a two-entry queue holds words while the
// permutation runs. result side is a queue: digest_word/digest_last are
// valid while empty is low and leave when pop is high.
// round_count is written on cfg_valid (cfg_ready always high); the user
// must write it only while the block is idle, which the block does not
// enforce; reset value is 20, values above 24 act as 24. words are taken
// back to back while idle; each full block of RATE_WORDS words adds a
// permutation, one round per cycle through a single round unit. a last
// word adds one permutation (two when a full final word ends a block)
// and then emits the digest words. a stalled receiver fills the two-entry
// result queue and holds the digest sequencer; the input queue fills
// behind it. reset clears state, word position and both queues at once.
module sponge_hash_2048_permutation
    import sh2048_pkg::*;
#(
    parameter int RATE_WORDS   = RATE_WORDS_DEF,
    parameter int DIGEST_WORDS = DIGEST_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] message_word,
    input  logic [6:0]  valid_bits,
    input  logic        last_word,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] digest_word,
    output logic        digest_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  round_count
);

    item_t item;
    logic  item_valid;
    logic  item_pop;

    sh2048_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .message_word (message_word),
        .valid_bits   (valid_bits),
        .last_word    (last_word),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop)
    );

    sh2048_back #(
        .RATE_WORDS   (RATE_WORDS),
        .DIGEST_WORDS (DIGEST_WORDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .round_count (round_count),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .digest_last (digest_last)
    );

endmodule
